[rtl/tdwq_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the tick delay wait queue.
// Depends on nothing; every other file of the block depends on it.
package tdwq_pkg;

   localparam int SLOTS        = 32;
   localparam int SLOT_BITS    = $clog2(SLOTS);
   localparam int SLOT_CNT_BITS = $clog2(SLOTS + 1);
   localparam int TASK_ID_BITS = 8;
   localparam int TICK_BITS    = 32;
   localparam int CMD_BITS     = 2;
   localparam int Q_DEPTH      = 2;
   localparam int Q_PTR_BITS   = $clog2(Q_DEPTH);
   localparam int Q_CNT_BITS   = $clog2(Q_DEPTH + 1);

   localparam logic [CMD_BITS-1:0] CMD_TICK      = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_QUERY     = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_DELAY_REL = 2'd2;
   localparam logic [CMD_BITS-1:0] CMD_DELAY_ABS = 2'd3;

   localparam logic KIND_TIME_REPLY = 1'b0;
   localparam logic KIND_WAKE_UP    = 1'b1;

   typedef enum logic [1:0] {
      OP_TICK,
      OP_QUERY,
      OP_DELAY
   } op_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   typedef struct packed {
      op_type                  op;
      logic                    relative;
      logic [TASK_ID_BITS-1:0] requester;
      logic [TICK_BITS-1:0]    amount;
   } item_type;

endpackage

[rtl/tdwq_req_if.sv]
`timescale 1ns / 1ps
// Request channel of the tick delay wait queue: valid, ready and one item.
// Depends on tdwq_pkg for the field widths.
interface tdwq_req_if;
   logic                                valid;
   logic                                ready;
   logic [tdwq_pkg::CMD_BITS-1:0]       command;
   logic [tdwq_pkg::TASK_ID_BITS-1:0]   requester;
   logic [tdwq_pkg::TICK_BITS-1:0]      amount;

   modport source (output valid, output command, output requester, output amount,
                   input ready);
   modport sink   (input valid, input command, input requester, input amount,
                   output ready);
endinterface

[rtl/tdwq_rsp_if.sv]
`timescale 1ns / 1ps
// Result channel of the tick delay wait queue: valid, ready and one item.
// Depends on tdwq_pkg for the field widths.
interface tdwq_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                kind;
   logic [tdwq_pkg::TASK_ID_BITS-1:0]   task_id;
   logic [tdwq_pkg::TICK_BITS-1:0]      tick_value;
   logic                                last;

   modport source (output valid, output kind, output task_id, output tick_value,
                   output last, input ready);
   modport sink   (input valid, input kind, input task_id, input tick_value,
                   input last, output ready);
endinterface

[rtl/tick_delay_wait_queue_top.sv]
`timescale 1ns / 1ps
// Top level of the tick delay wait queue: front end, item queue, execution unit.
// Depends on tdwq_pkg, tdwq_req_if, tdwq_rsp_if, tdwq_front, tdwq_queue, tdwq_back.
// A time query passes the front register, the item queue and the result register;
// delays give no result. A tick scans one slot per cycle unless results stall; up to
// three further items are taken meanwhile before the input stalls.
// Synchronous reset clears the count, all valid bits and restores the free slot list.
module tick_delay_wait_queue_top (
   input  logic       clock,
   input  logic       reset,
   tdwq_req_if.sink   req_ch,
   tdwq_rsp_if.source rsp_ch
);
   import tdwq_pkg::*;

   logic     fr_valid;
   logic     fr_ready;
   item_type fr_item;
   logic     q_valid;
   logic     q_ready;
   item_type q_item;

   tdwq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .out_valid (fr_valid),
      .out_item  (fr_item),
      .out_ready (fr_ready)
   );

   tdwq_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_item   (fr_item),
      .in_ready  (fr_ready),
      .out_valid (q_valid),
      .out_item  (q_item),
      .out_ready (q_ready)
   );

   tdwq_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (q_valid),
      .in_item  (q_item),
      .in_ready (q_ready),
      .rsp_ch   (rsp_ch)
   );

endmodule

[rtl/tdwq_front.sv]
`timescale 1ns / 1ps
// Front end: accepts request items, decodes the command and registers the item.
// Depends on tdwq_pkg and tdwq_req_if.
module tdwq_front (
   input  logic               clock,
   input  logic               reset,
   tdwq_req_if.sink           req_ch,
   output logic               out_valid,
   output tdwq_pkg::item_type out_item,
   input  logic               out_ready
);
   import tdwq_pkg::*;

   logic     vld_ff;
   logic     vld_in;
   item_type item_ff;
   item_type item_in;
   logic     take;

   assign req_ch.ready = !vld_ff || out_ready;
   assign take         = req_ch.valid && req_ch.ready;
   assign vld_in       = take || (vld_ff && !out_ready);

   always_comb begin
      item_in.requester = req_ch.requester;
      item_in.amount    = req_ch.amount;
      item_in.relative  = 1'b0;
      case (req_ch.command)
         CMD_TICK: begin
            item_in.op = OP_TICK;
         end
         CMD_QUERY: begin
            item_in.op = OP_QUERY;
         end
         CMD_DELAY_REL: begin
            item_in.op       = OP_DELAY;
            item_in.relative = 1'b1;
         end
         default: begin
            item_in.op = OP_DELAY;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_item  = item_ff;

endmodule

[rtl/tdwq_queue.sv]
`timescale 1ns / 1ps
// Short FIFO of decoded items between the front end and the execution unit.
// Depends on tdwq_pkg.
module tdwq_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  tdwq_pkg::item_type in_item,
   output logic               in_ready,
   output logic               out_valid,
   output tdwq_pkg::item_type out_item,
   input  logic               out_ready
);
   import tdwq_pkg::*;

   item_type                entry_ff [Q_DEPTH];
   logic [Q_PTR_BITS-1:0]   wr_ptr_ff;
   logic [Q_PTR_BITS-1:0]   wr_ptr_in;
   logic [Q_PTR_BITS-1:0]   rd_ptr_ff;
   logic [Q_PTR_BITS-1:0]   rd_ptr_in;
   logic [Q_CNT_BITS-1:0]   count_ff;
   logic [Q_CNT_BITS-1:0]   count_in;
   logic                    push;
   logic                    pop;

   assign in_ready  = count_ff != Q_CNT_BITS'(Q_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_item  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

[rtl/tdwq_back.sv]
`timescale 1ns / 1ps
// Execution unit: tick count, wait slot table, free slot list, slot scan on a
// tick and the registered result stage. Depends on tdwq_pkg and tdwq_rsp_if.
module tdwq_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  tdwq_pkg::item_type in_item,
   output logic               in_ready,
   tdwq_rsp_if.source         rsp_ch
);
   import tdwq_pkg::*;

   state_type                 st_ff;
   state_type                 st_in;
   logic [TICK_BITS-1:0]      tick_ff;
   logic [TICK_BITS-1:0]      tick_in;

   logic [TASK_ID_BITS-1:0]   task_mem [SLOTS];
   logic [TICK_BITS-1:0]      deadline_mem [SLOTS];
   logic [SLOTS-1:0]          slot_valid_ff;
   logic [SLOT_BITS-1:0]      free_fifo_ff [SLOTS];
   logic [SLOT_BITS-1:0]      free_rd_ptr_ff;
   logic [SLOT_BITS-1:0]      free_wr_ptr_ff;
   logic [SLOT_CNT_BITS-1:0]  free_count_ff;
   logic [SLOT_BITS-1:0]      alloc_slot;
   logic [TICK_BITS-1:0]      alloc_deadline;

   logic [SLOT_CNT_BITS-1:0]  scan_idx_ff;
   logic                      cmp_vld_ff;
   logic [SLOT_BITS-1:0]      cmp_idx_ff;
   logic [TASK_ID_BITS-1:0]   rd_task_ff;
   logic [TICK_BITS-1:0]      rd_deadline_ff;
   logic                      hold_vld_ff;
   logic [TASK_ID_BITS-1:0]   hold_task_ff;

   logic                      rsp_vld_ff;
   logic                      rsp_vld_in;
   logic                      rsp_kind_ff;
   logic [TASK_ID_BITS-1:0]   rsp_task_ff;
   logic [TICK_BITS-1:0]      rsp_tick_ff;
   logic                      rsp_last_ff;

   logic rsp_free;
   logic match;
   logic scan_done;
   logic pop;
   logic start_tick;
   logic alloc;
   logic load_query;
   logic emit_mid;
   logic emit_end;
   logic finish;
   logic release_slot;
   logic advance;

   assign rsp_free  = !rsp_vld_ff || rsp_ch.ready;
   assign match     = cmp_vld_ff && slot_valid_ff[cmp_idx_ff] && (rd_deadline_ff <= tick_ff);
   assign scan_done = (scan_idx_ff == SLOT_CNT_BITS'(SLOTS)) && !cmp_vld_ff;
   assign alloc_slot     = free_fifo_ff[free_rd_ptr_ff];
   assign alloc_deadline = in_item.relative ? tick_ff + in_item.amount : in_item.amount;

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: begin
            if (in_valid && in_item.op == OP_TICK) begin
               st_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done && (!hold_vld_ff || rsp_free)) begin
               st_in = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      pop          = 1'b0;
      start_tick   = 1'b0;
      alloc        = 1'b0;
      load_query   = 1'b0;
      emit_mid     = 1'b0;
      emit_end     = 1'b0;
      finish       = 1'b0;
      release_slot = 1'b0;
      advance      = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            if (in_valid) begin
               case (in_item.op)
                  OP_TICK: begin
                     pop        = 1'b1;
                     start_tick = 1'b1;
                  end
                  OP_QUERY: begin
                     pop        = rsp_free;
                     load_query = rsp_free;
                  end
                  default: begin
                     pop   = 1'b1;
                     alloc = free_count_ff != '0;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            emit_mid     = match && hold_vld_ff && rsp_free;
            release_slot = match && (!hold_vld_ff || rsp_free);
            advance      = !scan_done && (!match || !hold_vld_ff || rsp_free);
            emit_end     = scan_done && hold_vld_ff && rsp_free;
            finish       = scan_done && (!hold_vld_ff || rsp_free);
         end
         default: begin
         end
      endcase
   end

   assign in_ready   = pop;
   assign tick_in    = start_tick ? tick_ff + 1'b1 : tick_ff;
   assign rsp_vld_in = (load_query || emit_mid || emit_end) || (rsp_vld_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= ST_IDLE;
         tick_ff       <= '0;
         slot_valid_ff <= '0;
         free_rd_ptr_ff <= '0;
         free_wr_ptr_ff <= '0;
         free_count_ff <= SLOT_CNT_BITS'(SLOTS);
         for (int i = 0; i < SLOTS; i++) begin
            free_fifo_ff[i] <= SLOT_BITS'(i);
         end
         scan_idx_ff   <= '0;
         cmp_vld_ff    <= 1'b0;
         hold_vld_ff   <= 1'b0;
         rsp_vld_ff    <= 1'b0;
      end else begin
         st_ff      <= st_in;
         tick_ff    <= tick_in;
         rsp_vld_ff <= rsp_vld_in;
         if (alloc) begin
            slot_valid_ff[alloc_slot] <= 1'b1;
            free_rd_ptr_ff <= (free_rd_ptr_ff == SLOT_BITS'(SLOTS - 1)) ?
                              '0 : free_rd_ptr_ff + 1'b1;
            free_count_ff  <= free_count_ff - 1'b1;
         end
         if (release_slot) begin
            slot_valid_ff[cmp_idx_ff] <= 1'b0;
            if (free_count_ff != SLOT_CNT_BITS'(SLOTS)) begin
               free_fifo_ff[free_wr_ptr_ff] <= cmp_idx_ff;
               free_wr_ptr_ff <= (free_wr_ptr_ff == SLOT_BITS'(SLOTS - 1)) ?
                                 '0 : free_wr_ptr_ff + 1'b1;
               free_count_ff  <= free_count_ff + 1'b1;
            end
         end
         if (start_tick) begin
            scan_idx_ff <= '0;
            cmp_vld_ff  <= 1'b0;
            hold_vld_ff <= 1'b0;
         end
         if (advance) begin
            cmp_vld_ff <= scan_idx_ff < SLOT_CNT_BITS'(SLOTS);
            if (scan_idx_ff < SLOT_CNT_BITS'(SLOTS)) begin
               scan_idx_ff <= scan_idx_ff + 1'b1;
            end
         end
         if (release_slot) begin
            hold_vld_ff <= 1'b1;
         end else if (finish) begin
            hold_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cmp_idx_ff <= scan_idx_ff[SLOT_BITS-1:0];
      end
      if (release_slot) begin
         hold_task_ff <= rd_task_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (alloc) begin
         task_mem[alloc_slot]     <= in_item.requester;
         deadline_mem[alloc_slot] <= alloc_deadline;
      end
      if (advance && scan_idx_ff < SLOT_CNT_BITS'(SLOTS)) begin
         rd_task_ff     <= task_mem[scan_idx_ff[SLOT_BITS-1:0]];
         rd_deadline_ff <= deadline_mem[scan_idx_ff[SLOT_BITS-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (load_query) begin
         rsp_kind_ff <= KIND_TIME_REPLY;
         rsp_task_ff <= in_item.requester;
         rsp_tick_ff <= tick_ff;
         rsp_last_ff <= 1'b1;
      end else if (emit_mid || emit_end) begin
         rsp_kind_ff <= KIND_WAKE_UP;
         rsp_task_ff <= hold_task_ff;
         rsp_tick_ff <= tick_ff;
         rsp_last_ff <= emit_end;
      end
   end

   assign rsp_ch.valid      = rsp_vld_ff;
   assign rsp_ch.kind       = rsp_kind_ff;
   assign rsp_ch.task_id    = rsp_task_ff;
   assign rsp_ch.tick_value = rsp_tick_ff;
   assign rsp_ch.last       = rsp_last_ff;

endmodule

[tb/sv/tick_delay_wait_queue_checker.sv]
`timescale 1ns / 1ps
// Result checker for the tick delay wait queue: watches both channels, predicts
// the replies of every accepted item and compares them in order with the block.
// Depends on tdwq_pkg, tdwq_req_if and tdwq_rsp_if.
module tick_delay_wait_queue_checker (
   input  logic clock,
   input  logic reset,
   tdwq_req_if  req_ch,
   tdwq_rsp_if  rsp_ch,
   output int   fail_count,
   output int   pending,
   output int   checked_count
);
   import tdwq_pkg::*;

   typedef struct packed {
      logic                    kind;
      logic [TASK_ID_BITS-1:0] task_id;
      logic [TICK_BITS-1:0]    tick_value;
      logic                    last;
   } timer_reply_type;

   logic [TICK_BITS-1:0]    now_ticks;
   logic [TICK_BITS-1:0]    wake_at [SLOTS];
   logic [TASK_ID_BITS-1:0] sleeper [SLOTS];
   logic                    sleeping [SLOTS];
   logic [SLOT_BITS-1:0]    free_ring [SLOTS];
   int                      ring_head;
   int                      ring_tail;
   int                      free_slots;
   timer_reply_type         awaited_replies [$];

   initial begin
      fail_count    = 0;
      pending       = 0;
      checked_count = 0;
   end

   task automatic clear_timer();
      int i;
      now_ticks = '0;
      for (i = 0; i < SLOTS; i++) begin
         wake_at[i]   = '0;
         sleeper[i]   = '0;
         sleeping[i]  = 1'b0;
         free_ring[i] = SLOT_BITS'(i);
      end
      ring_head  = 0;
      ring_tail  = 0;
      free_slots = SLOTS;
      awaited_replies.delete();
   endtask

   task automatic predict_command(input logic [CMD_BITS-1:0]     cmd,
                                  input logic [TASK_ID_BITS-1:0] who,
                                  input logic [TICK_BITS-1:0]    amt);
      timer_reply_type      reply;
      logic [TICK_BITS-1:0] deadline;
      int                   released;
      int                   slot;
      int                   i;
      released = 0;
      case (cmd)
         CMD_TICK: begin
            now_ticks = now_ticks + 1'b1;
            for (i = 0; i < SLOTS; i++) begin
               if (sleeping[i] && wake_at[i] <= now_ticks) begin
                  reply.kind       = KIND_WAKE_UP;
                  reply.task_id    = sleeper[i];
                  reply.tick_value = now_ticks;
                  reply.last       = 1'b0;
                  awaited_replies.push_back(reply);
                  released++;
                  sleeping[i] = 1'b0;
                  if (free_slots < SLOTS) begin
                     free_ring[ring_tail] = SLOT_BITS'(i);
                     ring_tail = (ring_tail + 1) % SLOTS;
                     free_slots++;
                  end
               end
            end
            if (released > 0) begin
               reply = awaited_replies.pop_back();
               reply.last = 1'b1;
               awaited_replies.push_back(reply);
            end
         end
         CMD_QUERY: begin
            reply.kind       = KIND_TIME_REPLY;
            reply.task_id    = who;
            reply.tick_value = now_ticks;
            reply.last       = 1'b1;
            awaited_replies.push_back(reply);
         end
         default: begin
            deadline = (cmd == CMD_DELAY_REL) ? now_ticks + amt : amt;
            if (free_slots > 0) begin
               slot = int'(free_ring[ring_head]);
               ring_head = (ring_head + 1) % SLOTS;
               free_slots--;
               sleeper[slot]  = who;
               wake_at[slot]  = deadline;
               sleeping[slot] = 1'b1;
            end
         end
      endcase
   endtask

   task automatic check_reply();
      timer_reply_type want;
      if (awaited_replies.size() == 0) begin
         $display("%0t: unexpected result kind=%0d task_id=%0d tick_value=%0d last=%0d",
                  $time, rsp_ch.kind, rsp_ch.task_id, rsp_ch.tick_value, rsp_ch.last);
         fail_count++;
      end else begin
         want = awaited_replies.pop_front();
         checked_count++;
         if (rsp_ch.kind !== want.kind) begin
            $display("%0t: kind expected %0d, actual %0d", $time, want.kind, rsp_ch.kind);
            fail_count++;
         end
         if (rsp_ch.task_id !== want.task_id) begin
            $display("%0t: task_id expected %0d, actual %0d",
                     $time, want.task_id, rsp_ch.task_id);
            fail_count++;
         end
         if (rsp_ch.tick_value !== want.tick_value) begin
            $display("%0t: tick_value expected %0d, actual %0d",
                     $time, want.tick_value, rsp_ch.tick_value);
            fail_count++;
         end
         if (rsp_ch.last !== want.last) begin
            $display("%0t: last expected %0d, actual %0d", $time, want.last, rsp_ch.last);
            fail_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_timer();
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_command(req_ch.command, req_ch.requester, req_ch.amount);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            check_reply();
         end
      end
      pending = awaited_replies.size();
   end

endmodule

[tb/sv/tick_delay_wait_queue_top_test.sv]
`timescale 1ns / 1ps
// Top of the tick delay wait queue testbench: clock, reset, stimulus and verdict.
// Depends on tdwq_pkg, both channel interfaces, the block and the result checker.
module tick_delay_wait_queue_top_test;
   import tdwq_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int HOLD_CYCLES  = 400;
   localparam int RANDOM_ITEMS = 300;
   localparam int WIDE_DELAYS  = 4;

   logic clock     = 1'b0;
   logic reset     = 1'b1;
   logic req_taken = 1'b0;
   logic calm      = 1'b0;
   logic hold_rsp  = 1'b0;
   logic holding   = 1'b0;
   int   fail_count;
   int   pending;
   int   checked_count;
   int   cycle_count  = 0;
   int   items_sent   = 0;
   int   ticks_sent   = 0;
   int   queries_sent = 0;
   int   delays_sent  = 0;
   int   wide_left    = WIDE_DELAYS;

   tdwq_req_if req_if ();
   tdwq_rsp_if rsp_if ();

   tick_delay_wait_queue_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   tick_delay_wait_queue_checker reply_check (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_if),
      .rsp_ch        (rsp_if),
      .fail_count    (fail_count),
      .pending       (pending),
      .checked_count (checked_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      req_taken <= req_if.valid && req_if.ready;
   end

   function automatic int idle_length();
      if ($urandom_range(0, 99) < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(15, 50);
   endfunction

   function automatic int sender_gap();
      if (calm || $urandom_range(0, 99) < 60) begin
         return 0;
      end
      return idle_length();
   endfunction

   task automatic send_item(input logic [CMD_BITS-1:0]     cmd,
                            input logic [TASK_ID_BITS-1:0] who,
                            input logic [TICK_BITS-1:0]    amt);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         req_if.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid     = 1'b1;
      req_if.command   = cmd;
      req_if.requester = who;
      req_if.amount    = amt;
      do @(negedge clock); while (!req_taken);
      items_sent++;
      case (cmd)
         CMD_TICK:  ticks_sent++;
         CMD_QUERY: queries_sent++;
         default:   delays_sent++;
      endcase
   endtask

   task automatic send_random_delay();
      logic [TICK_BITS-1:0] amt;
      logic [TICK_BITS-1:0] base;
      logic [CMD_BITS-1:0]  cmd;
      int                   pick;
      pick = $urandom_range(0, 39);
      cmd  = CMD_DELAY_REL;
      if (pick == 0 && wide_left > 0) begin
         wide_left--;
         amt = $urandom;
      end else if (pick == 1) begin
         amt = 32'hFFFF_FFFF - $urandom_range(0, 1);
      end else if (pick < 20) begin
         amt = $urandom_range(0, 6);
      end else begin
         cmd  = CMD_DELAY_ABS;
         base = (ticks_sent > 3) ? ticks_sent - 3 : 0;
         amt  = base + $urandom_range(0, 8);
      end
      send_item(cmd, TASK_ID_BITS'($urandom_range(0, 255)), amt);
   endtask

   task automatic send_random(input int count);
      int stop_at;
      int pick;
      int n;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            send_item(CMD_TICK, TASK_ID_BITS'($urandom_range(0, 255)), $urandom);
         end else if (pick < 45) begin
            send_item(CMD_QUERY, TASK_ID_BITS'($urandom_range(0, 255)), $urandom);
         end else if (pick < 80) begin
            send_random_delay();
         end else if (pick < 88) begin
            n = $urandom_range(8, 40);
            repeat (n) send_random_delay();
            repeat ($urandom_range(1, 3))
               send_item(CMD_TICK, TASK_ID_BITS'($urandom_range(0, 255)), '0);
         end else begin
            repeat ($urandom_range(2, 6))
               send_item(CMD_TICK, TASK_ID_BITS'($urandom_range(0, 255)), '0);
         end
      end
   endtask

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_if.ready = 1'b0;
            holding = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            holding  = 1'b0;
            hold_rsp = 1'b0;
            rsp_if.ready = 1'b1;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_if.ready = 1'b0;
            repeat (idle_length() - 1) @(negedge clock);
         end else begin
            rsp_if.ready = 1'b1;
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tick_delay_wait_queue_top_test failed");
      $finish;
   end

   initial begin
      req_if.valid     = 1'b0;
      req_if.command   = CMD_TICK;
      req_if.requester = '0;
      req_if.amount    = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // An empty tick, deadlines already passed, a wrapping relative delay, a deadline
      // that never arrives and two tasks waking on the same tick.
      send_item(CMD_QUERY,     8'h00, '0);
      send_item(CMD_TICK,      8'h00, '0);
      send_item(CMD_QUERY,     8'hFF, 32'hFFFF_FFFF);
      send_item(CMD_DELAY_ABS, 8'hA5, 32'h0000_0000);
      send_item(CMD_DELAY_REL, 8'h5A, 32'h0000_0000);
      send_item(CMD_DELAY_ABS, 8'h01, 32'hFFFF_FFFF);
      send_item(CMD_DELAY_REL, 8'h02, 32'hFFFF_FFFF);
      send_item(CMD_DELAY_REL, 8'h03, 32'd2);
      send_item(CMD_TICK,      8'hFF, '0);
      send_item(CMD_TICK,      8'h00, '0);
      send_item(CMD_TICK,      8'h00, '0);
      send_item(CMD_QUERY,     8'h80, '0);
      send_item(CMD_DELAY_ABS, 8'h7F, 32'd5);
      send_item(CMD_DELAY_REL, 8'h10, 32'd1);
      send_item(CMD_TICK,      8'h00, '0);
      send_item(CMD_TICK,      8'h00, '0);
      send_item(CMD_QUERY,     8'h55, '0);

      req_if.valid = 1'b0;
      wait (pending == 0);
      @(negedge clock);

      send_random(100);

      // The receiver holds off while items keep coming, so the block backs up.
      hold_rsp = 1'b1;
      wait (holding);
      @(negedge clock);
      repeat (SLOTS + 2) send_item(CMD_DELAY_REL, TASK_ID_BITS'($urandom_range(0, 255)), '0);
      send_item(CMD_TICK, 8'h00, '0);
      repeat (16) send_item(CMD_QUERY, TASK_ID_BITS'($urandom_range(0, 255)), '0);
      req_if.valid = 1'b0;
      wait (pending == 0);
      @(negedge clock);

      calm = 1'b1;
      send_random(40);
      calm = 1'b0;
      send_random(RANDOM_ITEMS - items_sent);

      req_if.valid = 1'b0;
      wait (pending == 0);
      repeat (SLOTS + 20) @(posedge clock);
      $display("Sent %0d items: %0d ticks, %0d time queries, %0d delays.",
               items_sent, ticks_sent, queries_sent, delays_sent);
      $display("Checked %0d results, including a full table and a long result stall.",
               checked_count);
      if (fail_count == 0 && pending == 0) begin
         $display("tick_delay_wait_queue_top_test passed");
      end else begin
         $display("tick_delay_wait_queue_top_test failed");
      end
      $finish;
   end

endmodule
